// ===== hdl/kksm_pkg.sv =====
// Shared types and constants for the keystroke keyword suffix matcher.
// Used by the controller, the datapath and the top level; no dependencies.
package kksm_pkg;

    // Default sizes; the top level passes its parameters down
    localparam int MAX_WINDOW_DEF   = 32;
    localparam int NUM_KEYWORDS_DEF = 16;

    // Window length register
    localparam int                 WLEN_W     = 6;
    localparam logic [WLEN_W-1:0]  WLEN_RESET = 6'd20;

    // Input item fields
    localparam int OPCODE_W   = 2;
    localparam int KEY_W      = 8;
    localparam int SLOT_W     = 4;
    localparam int POSITION_W = 5;
    localparam int LENGTH_W   = 6;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = OPCODE_W;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 1;

    // Opcodes carried in s_tuser
    localparam logic [OPCODE_W-1:0] OP_KEY  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CHAR = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LEN  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic win_shift;   // shift a keystroke into the key window
        logic char_wr;     // write one keyword character
        logic len_wr;      // write one keyword length
        logic scan_init;   // start a scan at slot 0, clear the result
        logic slot_load;   // copy window to scan register, fetch slot length
        logic cmp_step;    // consume one scan register entry
        logic slot_adv;    // move to the next slot
        logic res_load;    // move the result into the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic len_zero;    // current slot disabled
        logic cmp_hit;     // last keyword character matched this cycle
        logic cmp_miss;    // slot cannot match
        logic last_slot;   // current slot is the highest one
        logic res_free;    // output register can take a result
    } sts_t;

endpackage

// ===== hdl/kksm_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; no package needed.
module kksm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/kksm_ctrl.sv =====
// Sequencing state machine: accepts items, walks keyword slots, hands off results.
// Depends on kksm_pkg for the command/status structs and opcodes.
module kksm_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [kksm_pkg::OPCODE_W-1:0]     opcode,
    input  kksm_pkg::sts_t                    sts,
    output kksm_pkg::cmd_t                    cmd
);
    import kksm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (opcode)
                        OP_KEY: begin
                            cmd.win_shift = 1'b1;
                            cmd.scan_init = 1'b1;
                            state_next    = ST_LOAD;
                        end
                        OP_CHAR: cmd.char_wr = 1'b1;
                        OP_LEN:  cmd.len_wr  = 1'b1;
                        default: ;  // unknown opcode: drop the transfer
                    endcase
                end
            end
            ST_LOAD: begin
                cmd.slot_load = 1'b1;
                if (sts.len_zero) begin
                    if (sts.last_slot) begin
                        state_next = ST_DONE;
                    end else begin
                        cmd.slot_adv = 1'b1;
                    end
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                cmd.cmp_step = 1'b1;
                if (sts.cmp_hit || sts.cmp_miss) begin
                    if (sts.last_slot) begin
                        state_next = ST_DONE;
                    end else begin
                        cmd.slot_adv = 1'b1;
                        state_next   = ST_LOAD;
                    end
                end
            end
            ST_DONE: begin
                if (sts.res_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/kksm_dpath.sv =====
// Datapath: key window, scan register, keyword length table, keyword RAM, result.
// Depends on kksm_pkg and instantiates kksm_ram for the keyword characters.
module kksm_dpath #(
    parameter int MAX_WINDOW   = kksm_pkg::MAX_WINDOW_DEF,
    parameter int NUM_KEYWORDS = kksm_pkg::NUM_KEYWORDS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [kksm_pkg::WLEN_W-1:0]       cfg_wr_data,
    input  logic [kksm_pkg::KEY_W-1:0]        key_code,
    input  logic [kksm_pkg::SLOT_W-1:0]       slot,
    input  logic [kksm_pkg::POSITION_W-1:0]   position,
    input  logic [kksm_pkg::LENGTH_W-1:0]     length,
    input  kksm_pkg::cmd_t                    cmd,
    output kksm_pkg::sts_t                    sts,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [kksm_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [kksm_pkg::M_TUSER_W-1:0]    m_tuser
);
    import kksm_pkg::*;

    localparam int PW    = $clog2(MAX_WINDOW);
    localparam int LW    = $clog2(MAX_WINDOW + 1);
    localparam int SW    = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
    localparam int SLW   = (SW > SLOT_W) ? SW : SLOT_W;
    localparam int PLW   = (PW > POSITION_W) ? PW : POSITION_W;
    localparam int AW    = SW + PW;
    localparam int DEPTH = 1 << AW;

    // Configuration
    logic [WLEN_W-1:0] wlen_reg;
    logic [LW-1:0]     wl_eff;

    // Key window and scan register (newest entry at MAX_WINDOW-1)
    logic [KEY_W-1:0] win_reg  [MAX_WINDOW];
    logic [KEY_W-1:0] win_next [MAX_WINDOW];
    logic [KEY_W-1:0] scan_reg [MAX_WINDOW];
    logic [KEY_W-1:0] scan_next[MAX_WINDOW];
    logic [KEY_W-1:0] tap;

    // Keyword lengths
    logic [LW-1:0] len_reg [NUM_KEYWORDS];
    logic [LW-1:0] len_in;
    logic [LW-1:0] len_cur;

    // Scan control
    logic [SW-1:0] slot_reg, slot_next;
    logic [LW-1:0] ptr_reg, ptr_next;
    logic [LW-1:0] steps_reg, steps_next;
    logic [LW-1:0] ptr_m1;
    logic          found_reg, found_next;
    logic [SW-1:0] best_reg, best_next;

    // Write decode
    logic [SLW-1:0] slot_ext;
    logic [PLW-1:0] pos_ext;
    logic           slot_ok, pos_ok;
    logic [SW-1:0]  wr_slot;
    logic [PW-1:0]  wr_pos;

    // Keyword RAM
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [KEY_W-1:0] kw_char;

    // Output register
    logic              m_valid_reg;
    logic              m_matched_reg;
    logic [SLOT_W-1:0] m_slot_reg;
    logic [SLW-1:0]    best_ext;

    assign wl_eff = (wlen_reg == '0) ? LW'(1) :
                    (32'(wlen_reg) > MAX_WINDOW) ? LW'(MAX_WINDOW) : LW'(wlen_reg);

    assign slot_ext = SLW'(slot);
    assign pos_ext  = PLW'(position);
    assign slot_ok  = 32'(slot) < NUM_KEYWORDS;
    assign pos_ok   = 32'(position) < MAX_WINDOW;
    assign wr_slot  = slot_ext[SW-1:0];
    assign wr_pos   = pos_ext[PW-1:0];
    assign wr_addr  = {wr_slot, wr_pos};

    // Clamp over-long keyword lengths to the window size
    assign len_in  = (32'(length) > MAX_WINDOW) ? LW'(MAX_WINDOW) : LW'(length);
    assign len_cur = len_reg[slot_reg];
    assign tap     = scan_reg[MAX_WINDOW-1];

    // Status
    assign sts.len_zero  = (len_cur == '0);
    assign sts.last_slot = (slot_reg == SW'(NUM_KEYWORDS - 1));
    assign sts.res_free  = !m_valid_reg || m_tready;
    assign sts.cmp_hit   = (steps_reg != '0) && (tap != '0) && (tap == kw_char)
                           && (ptr_reg == LW'(1));
    assign sts.cmp_miss  = (steps_reg == '0) || ((tap != '0) && (tap != kw_char));

    always_comb begin
        win_next   = win_reg;
        scan_next  = scan_reg;
        slot_next  = slot_reg;
        ptr_next   = ptr_reg;
        steps_next = steps_reg;
        found_next = found_reg;
        best_next  = best_reg;

        if (cmd.win_shift) begin
            for (int i = 0; i < MAX_WINDOW - 1; i++) begin
                win_next[i] = win_reg[i+1];
            end
            win_next[MAX_WINDOW-1] = key_code;
        end
        if (cmd.scan_init) begin
            slot_next  = '0;
            found_next = 1'b0;
            best_next  = '0;
        end
        if (cmd.slot_load) begin
            scan_next  = win_reg;
            ptr_next   = len_cur;
            steps_next = wl_eff;
        end
        if (cmd.cmp_step && (steps_reg != '0)) begin
            // Consume the newest entry; idle ticks leave the keyword pointer alone
            for (int i = MAX_WINDOW - 1; i > 0; i--) begin
                scan_next[i] = scan_reg[i-1];
            end
            scan_next[0] = '0;
            steps_next   = steps_reg - LW'(1);
            if (tap != '0) begin
                ptr_next = ptr_reg - LW'(1);
            end
        end
        if (cmd.cmp_step && sts.cmp_hit) begin
            found_next = 1'b1;
            best_next  = slot_reg;
        end
        if (cmd.slot_adv) begin
            slot_next = slot_reg + SW'(1);
        end
    end

    // Fetch the character the pointer will sit on next cycle
    assign ptr_m1  = ptr_next - LW'(1);
    assign rd_addr = {slot_reg, ptr_m1[PW-1:0]};

    kksm_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_kw_ram (
        .clk     (aclk),
        .wr_en   (cmd.char_wr && slot_ok && pos_ok),
        .wr_addr (wr_addr),
        .wr_data (key_code),
        .rd_addr (rd_addr),
        .rd_data (kw_char)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg  <= WLEN_RESET;
            slot_reg  <= '0;
            ptr_reg   <= '0;
            steps_reg <= '0;
            found_reg <= 1'b0;
            best_reg  <= '0;
            for (int i = 0; i < MAX_WINDOW; i++) begin
                win_reg[i] <= '0;
            end
            for (int s = 0; s < NUM_KEYWORDS; s++) begin
                len_reg[s] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                wlen_reg <= cfg_wr_data;
            end
            win_reg   <= win_next;
            slot_reg  <= slot_next;
            ptr_reg   <= ptr_next;
            steps_reg <= steps_next;
            found_reg <= found_next;
            best_reg  <= best_next;
            if (cmd.len_wr && slot_ok) begin
                len_reg[wr_slot] <= len_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
    end

    // Output register
    assign best_ext = SLW'(best_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            m_matched_reg <= found_reg;
            m_slot_reg    <= best_ext[SLOT_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_matched_reg;
    assign m_tdata  = {{(M_TDATA_W - SLOT_W){1'b0}}, m_slot_reg};

    a_hit_miss_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sts.cmp_hit && sts.cmp_miss))
        else $error("scan reports hit and miss together");

    a_res_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |=> m_valid_reg)
        else $error("loaded result not presented");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(ptr_reg) <= MAX_WINDOW) && (32'(steps_reg) <= MAX_WINDOW))
        else $error("scan counters out of range");

    a_no_match_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_matched_reg) |-> (m_slot_reg == '0))
        else $error("slot reported without a match");

endmodule

// ===== hdl/keystroke_keyword_suffix_matcher.sv =====
// Keystroke keyword suffix matcher: window of recent keys matched against a keyword table.
// A keyword write is taken in the idle state. A keystroke is accepted, then each slot gets a
// load step and, when enabled, compare steps: one per window entry scanned plus one when the
// window runs out; the result is then handed off once the output register is free.
// One item in flight; a new item is taken while the previous result waits in m_tdata.
// Reset: window cleared, lengths zero (all slots disabled), window_len 20; keyword chars
// stay undefined until written.
module keystroke_keyword_suffix_matcher #(
    parameter int MAX_WINDOW   = kksm_pkg::MAX_WINDOW_DEF,
    parameter int NUM_KEYWORDS = kksm_pkg::NUM_KEYWORDS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [kksm_pkg::WLEN_W-1:0]       cfg_wr_data,  // window_len
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] key_code, [11:8] slot, [16:12] position, [22:17] length, [23] zero
    input  logic [kksm_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [kksm_pkg::S_TUSER_W-1:0]    s_tuser,      // [1:0] opcode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [kksm_pkg::M_TDATA_W-1:0]    m_tdata,      // [3:0] match_slot, [7:4] zero
    output logic [kksm_pkg::M_TUSER_W-1:0]    m_tuser       // [0] matched
);
    import kksm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    kksm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    kksm_dpath #(
        .MAX_WINDOW   (MAX_WINDOW),
        .NUM_KEYWORDS (NUM_KEYWORDS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .key_code    (s_tdata[7:0]),
        .slot        (s_tdata[11:8]),
        .position    (s_tdata[16:12]),
        .length      (s_tdata[22:17]),
        .cmd         (cmd),
        .sts         (sts),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== verif/keystroke_keyword_suffix_matcher_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for keystroke_keyword_suffix_matcher: drives keystrokes and
// keyword table writes over the input stream and checks every match result against
// its own window and table model. Depends on kksm_pkg and the top level only.
module keystroke_keyword_suffix_matcher_tb;

    import kksm_pkg::*;

    localparam int MAX_WIN = MAX_WINDOW_DEF;
    localparam int NKW     = NUM_KEYWORDS_DEF;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic       matched;
        logic [3:0] slot;
    } match_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [WLEN_W-1:0]     cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    // Model state
    logic [7:0]        key_hist [MAX_WIN];
    logic [7:0]        kw_char [NKW][MAX_WIN];
    bit                kw_written [NKW][MAX_WIN];
    int                kw_len [NKW];
    logic [WLEN_W-1:0] wlen;

    match_t match_q[$];
    int     err_count;
    int     items_sent;
    int     keys_sent;
    int     writes_sent;
    int     cfg_writes;
    int     results_seen;
    int     hits_seen;
    int     long_hold;
    bit     idle_on;

    keystroke_keyword_suffix_matcher u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("timeout with %0d results outstanding", match_q.size());
        $display("keystroke_keyword_suffix_matcher_tb: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < 30) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        err_count++;
    endtask

    // Shift one key in, compact the live part of the window and find the highest hit.
    function automatic match_t predict_match(input logic [7:0] code);
        match_t     res;
        logic [7:0] seq [MAX_WIN];
        int         n;
        int         wl;
        int         kl;
        bit         eq;
        res.matched = 1'b0;
        res.slot    = 4'd0;
        n = 0;
        for (int i = 0; i < MAX_WIN - 1; i++) key_hist[i] = key_hist[i + 1];
        key_hist[MAX_WIN - 1] = code;
        wl = (wlen == 0) ? 1 : ((int'(wlen) > MAX_WIN) ? MAX_WIN : int'(wlen));
        for (int i = MAX_WIN - wl; i < MAX_WIN; i++) begin
            if (key_hist[i] != 8'h00) begin
                seq[n] = key_hist[i];
                n++;
            end
        end
        for (int s = 0; s < NKW; s++) begin
            kl = kw_len[s];
            if (kl != 0 && kl <= n) begin
                eq = 1'b1;
                for (int p = 0; p < kl; p++) begin
                    if (kw_char[s][p] != seq[n - kl + p]) eq = 1'b0;
                end
                if (eq) begin
                    res.matched = 1'b1;
                    res.slot    = 4'(s);
                end
            end
        end
        return res;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [7:0] code,
                             input logic [3:0] slot, input logic [4:0] pos,
                             input logic [5:0] len);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, len, pos, slot, code};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (op)
            OP_KEY: begin
                match_q.insert(match_q.size(), predict_match(code));
                keys_sent++;
                items_sent++;
            end
            OP_CHAR: begin
                kw_char[slot][pos]    = code;
                kw_written[slot][pos] = 1'b1;
                writes_sent++;
                items_sent++;
            end
            OP_LEN: begin
                kw_len[slot] = (int'(len) > MAX_WIN) ? MAX_WIN : int'(len);
                writes_sent++;
                items_sent++;
            end
            default: ;
        endcase
    endtask

    task automatic send_key(input logic [7:0] code);
        send_item(OP_KEY, code, 4'($urandom), 5'($urandom), 6'($urandom));
    endtask

    // Drop valid, wait for the last result and let any trailing write settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (match_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_window(input logic [WLEN_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        wlen = value;
        cfg_writes++;
    endtask

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(1, 255));
        return 8'(8'h61 + $urandom_range(0, 3));
    endfunction

    function automatic logic [5:0] pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3) return 6'd0;
        if (r < 17) return 6'($urandom_range(1, 5));
        return 6'($urandom_range(6, 63));
    endfunction

    task automatic load_keyword(input int slot, input string word);
        for (int i = 0; i < word.len(); i++) begin
            send_item(OP_CHAR, word[i], 4'(slot), 5'(i), 6'($urandom));
        end
        send_item(OP_LEN, 8'($urandom), 4'(slot), 5'($urandom), 6'(word.len()));
    endtask

    // Fill any character the new length would expose before enabling the entry.
    task automatic set_keyword_length(input int slot, input logic [5:0] len);
        int eff;
        eff = (int'(len) > MAX_WIN) ? MAX_WIN : int'(len);
        for (int p = 0; p < eff; p++) begin
            if (!kw_written[slot][p]) begin
                send_item(OP_CHAR, pick_char(), 4'(slot), 5'(p), 6'($urandom));
            end
        end
        send_item(OP_LEN, 8'($urandom), 4'(slot), 5'($urandom), len);
    endtask

    task automatic type_keyword(input int slot, input bit broken);
        int stop;
        stop = kw_len[slot];
        if (broken && stop > 0) stop = $urandom_range(0, stop - 1);
        for (int p = 0; p < stop; p++) begin
            if ($urandom_range(0, 5) == 0) send_key(8'h00);
            send_key(kw_char[slot][p]);
        end
    endtask

    task automatic test_empty_table();
        send_key(8'h00);
        send_key(8'hFF);
        send_key(8'h01);
    endtask

    // Slot 5 holds a longer keyword ending in the same key as slot 0.
    task automatic test_slot_priority();
        load_keyword(0, "a");
        load_keyword(5, "ba");
        send_key(8'h62);
        send_key(8'h61);
        send_key(8'h00);
        send_key(8'h63);
        send_key(8'h61);
    endtask

    // An ignored opcode that looks like a length write must not disable slot 5.
    task automatic test_unknown_opcode();
        send_item(OP_UNUSED, 8'h78, 4'd5, 5'd0, 6'd0);
        send_key(8'h62);
        send_key(8'h61);
    endtask

    task automatic test_window_length();
        write_window(6'd1);
        send_key(8'h62);
        send_key(8'h61);
        send_key(8'h00);
        write_window(6'd20);
        send_key(8'h00);
        write_window(6'd0);
        send_key(8'h61);
        write_window(6'd33);
        send_key(8'h00);
        write_window(6'd63);
        send_key(8'h62);
        send_key(8'h61);
        write_window(6'd20);
    endtask

    task automatic test_long_keyword();
        write_window(6'd32);
        set_keyword_length(15, 6'd45);
        type_keyword(15, 1'b0);
        send_key(pick_char());
        write_window(6'd31);
        type_keyword(15, 1'b0);
        write_window(6'd63);
        type_keyword(15, 1'b0);
        send_item(OP_LEN, 8'h00, 4'd15, 5'd0, 6'd0);
        write_window(6'd20);
    endtask

    task automatic test_backpressure();
        wait_idle();
        idle_on   = 1'b0;
        long_hold = 600;
        for (int i = 0; i < 12; i++) send_key((i % 2) ? 8'h61 : 8'h62);
        wait_idle();
        idle_on = 1'b1;
    endtask

    task automatic test_random();
        logic [WLEN_W-1:0] settings [5];
        int                target;
        int                pick;
        logic [7:0]        code;
        settings[0] = 6'd20;
        settings[1] = 6'($urandom_range(2, 31));
        settings[2] = 6'd63;
        settings[3] = 6'd1;
        settings[4] = 6'd32;
        for (int ph = 0; ph < 5; ph++) begin
            write_window(settings[ph]);
            // Quiet last phase: no gaps and no stalls
            if (ph == 4) idle_on = 1'b0;
            for (int k = 0; k < 4; k++) set_keyword_length($urandom_range(0, NKW - 1), pick_len());
            target = items_sent + 180;
            while (items_sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    if ($urandom_range(0, 2) == 0) send_key(pick_char());
                    type_keyword($urandom_range(0, NKW - 1), $urandom_range(0, 4) == 0);
                end else if (pick < 70) begin
                    case ($urandom_range(0, 3))
                        0:       code = 8'h00;
                        3:       code = 8'($urandom_range(0, 255));
                        default: code = pick_char();
                    endcase
                    send_key(code);
                end else if (pick < 82) begin
                    send_item(OP_CHAR, ($urandom_range(0, 3) == 0) ? 8'($urandom) : pick_char(),
                              4'($urandom), 5'($urandom), 6'($urandom));
                end else if (pick < 92) begin
                    set_keyword_length($urandom_range(0, NKW - 1), pick_len());
                end else if (pick < 96) begin
                    send_item(OP_UNUSED, 8'($urandom), 4'($urandom), 5'($urandom), 6'($urandom));
                end else begin
                    send_key(8'h00);
                end
            end
        end
    endtask

    // Check each result transfer and pace m_tready.
    initial begin : result_check
        match_t want;
        int     stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                results_seen++;
                if (match_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                end else begin
                    want = match_q.pop_front();
                    if (m_tuser[0] !== want.matched) begin
                        report_mismatch($sformatf("result %0d matched %b, want %b",
                                                  results_seen, m_tuser[0], want.matched));
                    end
                    if (m_tdata[3:0] !== want.slot) begin
                        report_mismatch($sformatf("result %0d match_slot %0d, want %0d",
                                                  results_seen, m_tdata[3:0], want.slot));
                    end
                    if (want.matched) hits_seen++;
                end
            end
            if (long_hold > 0) begin
                long_hold--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 16);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        err_count    = 0;
        items_sent   = 0;
        keys_sent    = 0;
        writes_sent  = 0;
        cfg_writes   = 0;
        results_seen = 0;
        hits_seen    = 0;
        long_hold    = 0;
        idle_on      = 1'b1;
        wlen         = WLEN_RESET;
        for (int i = 0; i < MAX_WIN; i++) key_hist[i] = 8'h00;
        for (int s = 0; s < NKW; s++) begin
            kw_len[s] = 0;
            for (int p = 0; p < MAX_WIN; p++) begin
                kw_char[s][p]    = 8'h00;
                kw_written[s][p] = 1'b0;
            end
        end
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_empty_table();
        test_slot_priority();
        test_unknown_opcode();
        test_window_length();
        test_long_keyword();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (600) @(posedge aclk);
        if (match_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived", match_q.size()));
        end
        $display("run covered %0d keystrokes (%0d hits) and %0d table writes",
                 keys_sent, hits_seen, writes_sent);
        $display("window length written %0d times, %0d results checked, %0d mismatches",
                 cfg_writes, results_seen, err_count);
        if (err_count == 0) begin
            $display("keystroke_keyword_suffix_matcher_tb: done, clean");
        end else begin
            $display("keystroke_keyword_suffix_matcher_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== keystroke_keyword_suffix_matcher.f =====
hdl/kksm_pkg.sv
hdl/kksm_ram.sv
hdl/kksm_ctrl.sv
hdl/kksm_dpath.sv
hdl/keystroke_keyword_suffix_matcher.sv
verif/keystroke_keyword_suffix_matcher_tb.sv
